// ===== sv/cedq_pkg.sv =====
package cedq_pkg;

    // Largest row the error memory can hold, and the widths that follow from it.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W     = COL_W + 1;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int LEV_W      = 8;
    localparam int LW_W       = 12;
    localparam int ERR_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Width used to compare the column count against the configured row width.
    localparam int CMP_W = (CNT_W > LW_W) ? CNT_W : LW_W;

    // Divider: a 16-bit dividend (k*255) by the 8-bit level count.
    localparam int NUM_W     = 16;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEV_W-1:0] LEVELS_RESET     = LEV_W'(1);
    localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = LW_W'(2048);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVELS     = 1'b0,
        CFG_LINE_WIDTH = 1'b1
    } cfg_index_t;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [LEV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PIX_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== sv/column_error_diffusion_quantizer.sv =====
// Column error-diffusion quantizer.
// Grey pixels enter in raster order on the s_t* channel, one word per pixel:
// s_tdata carries the 8-bit pixel and s_tuser marks the first pixel of a frame.
// Each pixel is quantized to one of levels+1 steps and leaves as one word on
// the m_t* channel. The quantization error of each pixel is kept in a per-column
// memory and added to the pixel of the same column in the next row.
// The cfg_* channel writes the registers (index 0: levels, index 1: line_width);
// it is always ready and is meant to be written while no pixel is in flight.
// The 16-step serial divider scales the step index back to the pixel range,
// and the next pixel is accepted only once the finished word has been loaded
// into the output register. The sequencer works on one pixel at a time; if
// the receiver stalls, the finished word waits in the output register while
// the next pixel is already accepted and processed, and that one waits in the
// divider until the register frees.
// Reset returns levels to 1, line_width to 2048 and restarts the first row;
// the error memory is not cleared, since the first row discards what it reads.
module column_error_diffusion_quantizer (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input pixel stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_in
    input  logic                             s_tuser,   // [0] frame_start
    // Quantized pixel stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] pixel_out
    // Register write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cedq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cedq_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int T_W = 17;   // signed width of pixel*levels + error
    localparam int X_W = 16;   // unsigned width of the rounding offset sum

    // One-hot sequencer: wait for a pixel, read the column error, quantize and
    // write back, then divide and hand the result to the output register.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_QUANT = 4'b0100,
        S_DIV   = 4'b1000
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;

    logic [cedq_pkg::LEV_W-1:0]            levels_reg;
    logic [cedq_pkg::LW_W-1:0]             line_width_reg;
    logic [cedq_pkg::COL_W-1:0]            col_reg;
    logic                                  first_row_reg;

    logic [cedq_pkg::COL_W-1:0]            item_col_reg;
    logic                                  item_first_reg;
    logic [cedq_pkg::PIX_W-1:0]            pix_reg;
    logic signed [T_W-1:0]                 t_reg;

    logic                                  out_valid_reg;
    logic [cedq_pkg::PIX_W-1:0]            out_data_reg;

    logic                                  accept;
    logic [cedq_pkg::LEV_W-1:0]            lev_eff;
    logic [cedq_pkg::CMP_W-1:0]            width_eff;
    logic [cedq_pkg::CMP_W-1:0]            lw_ext;
    logic [cedq_pkg::COL_W-1:0]            cur_col;
    logic                                  cur_first;
    logic [cedq_pkg::CNT_W-1:0]            cnt_inc;
    logic                                  wrap;

    cedq_pkg::err_t                        mem_rd_data;
    cedq_pkg::err_t                        err_sel;
    logic [2*cedq_pkg::PIX_W-1:0]          prod;
    logic signed [T_W-1:0]                 t_next;

    logic signed [T_W-1:0]                 x_full;
    logic [X_W-1:0]                        x;
    logic [X_W+7:0]                        x257;
    logic [7:0]                            k_est;
    logic [X_W:0]                          k255;
    logic [X_W:0]                          r0;
    logic                                  r_ge;
    logic [X_W:0]                          r_fix;
    logic [8:0]                            k;
    logic [X_W:0]                          num_full;
    cedq_pkg::err_t                        err_new;

    logic                                  mem_rd_en;
    logic                                  mem_wr_en;
    logic                                  out_load;
    cedq_pkg::div_req_t                    div_req;
    cedq_pkg::div_rsp_t                    div_rsp;

    // ------------------------------------------------------------------
    // Register port. Levels of zero count as one; a width of zero counts as
    // one and a width beyond the memory saturates to its size.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg     <= cedq_pkg::LEVELS_RESET;
            line_width_reg <= cedq_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cedq_pkg::CFG_LEVELS:     levels_reg     <= cfg_data[cedq_pkg::LEV_W-1:0];
                cedq_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_data[cedq_pkg::LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lev_eff = (levels_reg == '0) ? cedq_pkg::LEV_W'(1) : levels_reg;
        lw_ext  = cedq_pkg::CMP_W'(line_width_reg);
        if (lw_ext == '0)
        begin
            width_eff = cedq_pkg::CMP_W'(1);
        end
        else if (lw_ext > cedq_pkg::CMP_W'(cedq_pkg::MAX_WIDTH))
        begin
            width_eff = cedq_pkg::CMP_W'(cedq_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = lw_ext;
        end
    end

    // ------------------------------------------------------------------
    // Column tracking. A frame start forces column zero and the first row
    // for this pixel; the count wraps once it reaches the row width.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        cur_col   = s_tuser ? '0 : col_reg;
        cur_first = s_tuser | first_row_reg;
        cnt_inc   = cedq_pkg::CNT_W'(cur_col) + 1'b1;
        wrap      = cedq_pkg::CMP_W'(cnt_inc) >= width_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else if (accept)
        begin
            col_reg       <= wrap ? '0 : cnt_inc[cedq_pkg::COL_W-1:0];
            first_row_reg <= wrap ? 1'b0 : cur_first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_col_reg   <= cur_col;
            item_first_reg <= cur_first;
            pix_reg        <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Error memory: read at acceptance, written back during quantization.
    // ------------------------------------------------------------------
    assign mem_rd_en = accept;
    assign mem_wr_en = (state_reg == S_QUANT);

    cedq_err_mem u_err_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (cur_col),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (item_col_reg),
        .wr_data (err_new)
    );

    // Read cycle: the weighted pixel plus the carried error. The first row of a
    // frame carries no error.
    always_comb
    begin
        err_sel = item_first_reg ? '0 : mem_rd_data;
        prod    = pix_reg * lev_eff;
        t_next  = $signed({1'b0, prod})
                + $signed({{(T_W - cedq_pkg::ERR_W){err_sel[cedq_pkg::ERR_W-1]}}, err_sel});
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            t_reg <= t_next;
        end
    end

    // Quantize cycle: k = floor((T+127)/255) by multiplying with 257/65536,
    // which is at most one low, then one compare-and-subtract. The remainder
    // less 127 is the new column error.
    always_comb
    begin
        x_full   = t_reg + T_W'(127);
        x        = x_full[X_W-1:0];
        x257     = {x, 8'h00} + {8'h00, x};
        k_est    = x257[X_W+7:X_W];
        k255     = {1'b0, k_est, 8'h00} - {9'h000, k_est};
        r0       = {1'b0, x} - k255;
        r_ge     = r0 >= (X_W+1)'(255);
        r_fix    = r_ge ? (r0 - (X_W+1)'(255)) : r0;
        k        = {1'b0, k_est} + {8'h00, r_ge};
        num_full = {k, 8'h00} - {8'h00, k};
        err_new  = cedq_pkg::err_t'(r_fix[7:0] - 8'd127);
    end

    // Output level: floor(k*255/levels) from the serial divider.
    assign div_req.start = (state_reg == S_QUANT);
    assign div_req.num   = num_full[cedq_pkg::NUM_W-1:0];
    assign div_req.den   = lev_eff;

    cedq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer and output register.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_DIV) && div_rsp.done && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept)   state_next = S_READ;
            S_READ:                state_next = S_QUANT;
            S_QUANT:               state_next = S_DIV;
            S_DIV:   if (out_load) state_next = S_IDLE;
            default:               state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= div_rsp.quot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // An accepted pixel is followed by the memory read cycle.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted pixel did not enter the read cycle");

    // The error memory is never read and written in the same cycle.
    a_mem_ports: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("error memory read and written in one cycle");

    // After the single correction the remainder is below 255, so the stored
    // error stays within -127..127.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QUANT) |-> (r_fix <= (X_W+1)'(254)))
        else $error("rounding remainder out of range");

    // While waiting on the divider it is either running or holding a result.
    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("divider idle while sequencer waits on it");

    // A loaded result appears on the output in the next cycle.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && (m_tdata == $past(div_rsp.quot))))
        else $error("quantized word not presented after load");

endmodule

// ===== sv/cedq_err_mem.sv =====
module cedq_err_mem (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [cedq_pkg::COL_W-1:0]  rd_addr,
    output cedq_pkg::err_t              rd_data,
    input  logic                        wr_en,
    input  logic [cedq_pkg::COL_W-1:0]  wr_addr,
    input  cedq_pkg::err_t              wr_data
);

    // One signed error per column; the read data is registered.
    cedq_pkg::err_t mem [cedq_pkg::MAX_WIDTH];
    cedq_pkg::err_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/cedq_div.sv =====
module cedq_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cedq_pkg::div_req_t req,
    output cedq_pkg::div_rsp_t rsp
);

    // Restoring divider, one quotient bit per cycle. The quotient is clamped to
    // the pixel range when presented.
    logic                             busy_reg;
    logic                             done_reg;
    logic [cedq_pkg::DIV_CNT_W-1:0]   step_reg;
    logic [cedq_pkg::NUM_W-1:0]       num_reg;
    logic [cedq_pkg::LEV_W-1:0]       rem_reg;
    logic [cedq_pkg::LEV_W-1:0]       den_reg;

    logic [cedq_pkg::LEV_W:0]         rem_shift;
    logic [cedq_pkg::LEV_W+1:0]       diff;
    logic                             ge;
    logic [cedq_pkg::LEV_W-1:0]       rem_next;
    logic [cedq_pkg::NUM_W-1:0]       num_next;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[cedq_pkg::NUM_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, den_reg};
        ge        = ~diff[cedq_pkg::LEV_W+1];
        rem_next  = ge ? diff[cedq_pkg::LEV_W-1:0] : rem_shift[cedq_pkg::LEV_W-1:0];
        num_next  = {num_reg[cedq_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= cedq_pkg::DIV_CNT_W'(cedq_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = (num_reg[cedq_pkg::NUM_W-1:cedq_pkg::PIX_W] != '0)
                      ? '1 : num_reg[cedq_pkg::PIX_W-1:0];

endmodule
